// File: rtl/core/erdm_pkg.sv
`timescale 1ns / 1ps

package erdm_pkg;

   // Transaction kinds on the request side
   localparam logic [1:0] KIND_CLEAR  = 2'd0;
   localparam logic [1:0] KIND_BYTE   = 2'd1;
   localparam logic [1:0] KIND_LOOKUP = 2'd2;

   // Response kinds
   localparam logic RKIND_RUN    = 1'b0;
   localparam logic RKIND_LOOKUP = 1'b1;

   // Widest length or offset field that a header may announce
   localparam logic [3:0] MAX_FIELD_BYTES = 4'd8;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_LENGTH = 2'd1,
      PH_OFFSET = 2'd2,
      PH_STOP   = 2'd3
   } phase_type;

   // One completed run, written into the extent cell chain
   typedef struct packed {
      logic        valid;
      logic        sparse;
      logic [31:0] start;
      logic [31:0] lcn;
      logic [31:0] length;
   } run_write_type;

   // Lookup token handed from cell to cell
   typedef struct packed {
      logic        valid;
      logic        done;
      logic        found;
      logic        sparse;
      logic [31:0] vcn;
      logic [31:0] run_start;
      logic [31:0] offset;
      logic [31:0] length;
      logic [31:0] lcn;
   } lookup_token_type;

endpackage

// File: rtl/core/erdm_parser.sv
`timescale 1ns / 1ps

module erdm_parser #(
   parameter int MAX_RUNS = 256,
   parameter int CNT_W    = 9
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   clear,
   input  logic                   byte_fire,
   input  logic [7:0]             data_byte,
   input  logic [31:0]            base_vcn,
   output erdm_pkg::run_write_type run_wr,
   output logic [CNT_W-1:0]       count
);
   import erdm_pkg::*;

   phase_type          phase_ff, phase_in;
   logic [3:0]         idx_ff, idx_in;
   logic [3:0]         lw_ff, lw_in;
   logic [3:0]         ow_ff, ow_in;
   logic [31:0]        len_ff, len_in;
   logic [31:0]        delta_ff, delta_in;
   logic [31:0]        lcn_ff, lcn_in;
   logic [31:0]        vcn_ff, vcn_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   logic [3:0]  hdr_lw, hdr_ow;
   logic        hdr_bad;
   logic [4:0]  idx_inc;
   logic        len_last, off_last;
   logic [31:0] byte_sh;
   logic [31:0] len_new, delta_new, lcn_new;
   logic        sign_ext;

   // Header decode and the byte placed at its little-endian position
   assign hdr_lw   = data_byte[3:0];
   assign hdr_ow   = data_byte[7:4];
   assign hdr_bad  = (data_byte == 8'd0) || (hdr_lw == 4'd0) || (hdr_lw > MAX_FIELD_BYTES)
                     || (hdr_ow > MAX_FIELD_BYTES)
                     || ({1'b0, count_ff} >= (CNT_W+1)'(MAX_RUNS));
   assign idx_inc  = {1'b0, idx_ff} + 5'd1;
   assign len_last = idx_inc >= {1'b0, lw_ff};
   assign off_last = idx_inc >= {1'b0, ow_ff};
   assign byte_sh  = {24'd0, data_byte} << {idx_ff[1:0], 3'b000};

   assign len_new  = (idx_ff < 4'd4) ? (len_ff | byte_sh) : len_ff;

   // short deltas are sign-extended from the top byte
   assign sign_ext  = (idx_inc == {1'b0, ow_ff}) && (ow_ff < 4'd4) && data_byte[7];
   always_comb begin
      delta_new = (idx_ff < 4'd4) ? (delta_ff | byte_sh) : delta_ff;
      if (sign_ext) begin
         delta_new = delta_new | (32'hFFFF_FFFF << {ow_ff[1:0], 3'b000});
      end
   end
   assign lcn_new = lcn_ff + delta_new;

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (clear) begin
         phase_in = PH_HEADER;
      end else if (byte_fire) begin
         unique case (phase_ff)
            PH_HEADER: phase_in = hdr_bad ? PH_STOP : PH_LENGTH;
            PH_LENGTH: begin
               if (len_last) begin
                  if (ow_ff != 4'd0) begin
                     phase_in = PH_OFFSET;
                  end else begin
                     phase_in = (len_new != 32'd0) ? PH_HEADER : PH_STOP;
                  end
               end
            end
            PH_OFFSET: begin
               if (off_last) begin
                  phase_in = (len_ff != 32'd0) ? PH_HEADER : PH_STOP;
               end
            end
            PH_STOP:   phase_in = PH_STOP;
         endcase
      end
   end

   // Accumulators, running clusters and the run write
   always_comb begin
      idx_in   = idx_ff;
      lw_in    = lw_ff;
      ow_in    = ow_ff;
      len_in   = len_ff;
      delta_in = delta_ff;
      lcn_in   = lcn_ff;
      vcn_in   = vcn_ff;
      count_in = count_ff;
      run_wr   = '0;
      if (clear) begin
         idx_in   = 4'd0;
         lw_in    = 4'd0;
         ow_in    = 4'd0;
         len_in   = 32'd0;
         delta_in = 32'd0;
         lcn_in   = 32'd0;
         vcn_in   = base_vcn;
         count_in = '0;
      end else if (byte_fire) begin
         unique case (phase_ff)
            PH_HEADER: begin
               lw_in = hdr_lw;
               ow_in = hdr_ow;
               if (!hdr_bad) begin
                  idx_in   = 4'd0;
                  len_in   = 32'd0;
                  delta_in = 32'd0;
               end
            end
            PH_LENGTH: begin
               len_in = len_new;
               idx_in = idx_inc[3:0];
               if (len_last) begin
                  if (ow_ff != 4'd0) begin
                     idx_in = 4'd0;
                  end else if (len_new != 32'd0) begin
                     // no offset field: a hole
                     run_wr.valid  = 1'b1;
                     run_wr.sparse = 1'b1;
                     run_wr.start  = vcn_ff;
                     run_wr.lcn    = 32'd0;
                     run_wr.length = len_new;
                     count_in      = count_ff + 1'b1;
                     vcn_in        = vcn_ff + len_new;
                  end
               end
            end
            PH_OFFSET: begin
               delta_in = delta_new;
               idx_in   = idx_inc[3:0];
               if (off_last) begin
                  lcn_in = lcn_new;
                  if (len_ff != 32'd0) begin
                     run_wr.valid  = 1'b1;
                     run_wr.sparse = 1'b0;
                     run_wr.start  = vcn_ff;
                     run_wr.lcn    = lcn_new;
                     run_wr.length = len_ff;
                     count_in      = count_ff + 1'b1;
                     vcn_in        = vcn_ff + len_ff;
                  end
               end
            end
            PH_STOP: begin
               idx_in = idx_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         idx_ff   <= 4'd0;
         lw_ff    <= 4'd0;
         ow_ff    <= 4'd0;
         len_ff   <= 32'd0;
         delta_ff <= 32'd0;
         lcn_ff   <= 32'd0;
         vcn_ff   <= 32'd0;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         lw_ff    <= lw_in;
         ow_ff    <= ow_in;
         len_ff   <= len_in;
         delta_ff <= delta_in;
         lcn_ff   <= lcn_in;
         vcn_ff   <= vcn_in;
         count_ff <= count_in;
      end
   end

   assign count = count_ff;

endmodule

// File: rtl/core/erdm_cell.sv
`timescale 1ns / 1ps

module erdm_cell #(
   parameter int CNT_W = 9
) (
   input  logic                       clock,
   input  logic                       reset,
   input  erdm_pkg::run_write_type    run_wr,
   input  erdm_pkg::lookup_token_type tok_in,
   input  logic [CNT_W-1:0]           left_in,
   output erdm_pkg::lookup_token_type tok_out,
   output logic [CNT_W-1:0]           left_out
);
   import erdm_pkg::*;

   // One stored extent
   logic             sparse_ff;
   logic [31:0]      start_ff;
   logic [31:0]      lcn_ff;
   logic [31:0]      length_ff;

   lookup_token_type tok_ff, tok_in_c;
   logic [CNT_W-1:0] left_ff, left_in_c;

   logic [32:0]      diff;
   logic             hit;

   always_ff @(posedge clock) begin
      if (run_wr.valid) begin
         sparse_ff <= run_wr.sparse;
         start_ff  <= run_wr.start;
         lcn_ff    <= run_wr.lcn;
         length_ff <= run_wr.length;
      end
   end

   // Containment test, exact across the top of the cluster space
   assign diff = {1'b0, tok_in.vcn} - {1'b0, start_ff};
   assign hit  = !diff[32] && (diff[31:0] < length_ff);

   // First match wins; an exhausted entry count ends the walk as a miss
   always_comb begin
      tok_in_c  = tok_in;
      left_in_c = left_in;
      if (tok_in.valid && !tok_in.done) begin
         if (left_in == '0) begin
            tok_in_c.done = 1'b1;
         end else if (hit) begin
            tok_in_c.done      = 1'b1;
            tok_in_c.found     = 1'b1;
            tok_in_c.sparse    = sparse_ff;
            tok_in_c.run_start = start_ff;
            tok_in_c.offset    = diff[31:0];
            tok_in_c.length    = length_ff;
            tok_in_c.lcn       = lcn_ff;
         end else begin
            left_in_c = left_in - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_c;
      end
      left_ff <= left_in_c;
   end

   assign tok_out  = tok_ff;
   assign left_out = left_ff;

endmodule

// File: rtl/core/extent_runlist_decode_and_map.sv
`timescale 1ns / 1ps

// Extent runlist decoder and cluster mapper. A transaction is taken when start is high and
// busy is low. Clear and runlist-byte transactions do not raise busy; a byte that completes
// a run of nonzero length gives a run response in the following cycle. A lookup walks a chain
// of MAX_RUNS extent cells, the query moving one cell per clock, so busy stays high until the
// query leaves the last cell and the answer is strobed in the cycle busy falls, when the next
// transaction may already be taken. Every response is on the rsp_ ports for exactly one cycle
// with rsp_strobe high; the receiver cannot stall it and must capture it then. The base
// cluster written over the csr_ port is picked up at the next clear.

module extent_runlist_decode_and_map #(
   parameter int MAX_RUNS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_data_byte,
   input  logic [31:0] req_query_vcn,
   output logic        rsp_strobe,
   output logic        rsp_result_kind,
   output logic        rsp_found,
   output logic [31:0] rsp_run_start,
   output logic [31:0] rsp_mapped_lcn,
   output logic [31:0] rsp_run_length,
   output logic [31:0] rsp_clusters_left,
   output logic        rsp_is_sparse,
   output logic [8:0]  rsp_run_count,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data
);
   import erdm_pkg::*;

   localparam int CNT_W = $clog2(MAX_RUNS + 1);
   localparam int IDX_W = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;

   logic             fire, clear, byte_fire, lookup_fire;
   logic [31:0]      base_vcn_ff;
   logic             busy_ff, busy_in;
   run_write_type    run_wr;
   logic [CNT_W-1:0] count;

   lookup_token_type tok   [MAX_RUNS+1];
   logic [CNT_W-1:0] left  [MAX_RUNS+1];
   lookup_token_type last_tok;

   logic             strobe_ff, strobe_in;
   logic             kind_ff, kind_in;
   logic             found_ff, found_in;
   logic [31:0]      start_ff, start_in;
   logic [31:0]      mapped_ff, mapped_in;
   logic [31:0]      length_ff, length_in;
   logic [31:0]      cleft_ff, cleft_in;
   logic             sparse_ff, sparse_in;
   logic [8:0]       rcount_ff, rcount_in;
   logic [CNT_W-1:0] rcount_sel;
   logic [CNT_W+8:0] rcount_ext;

   assign fire        = start && !busy_ff;
   assign clear       = fire && (req_kind == KIND_CLEAR);
   assign byte_fire   = fire && (req_kind == KIND_BYTE);
   assign lookup_fire = fire && (req_kind == KIND_LOOKUP);

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         base_vcn_ff <= 32'd0;
      end else if (csr_write_enable) begin
         base_vcn_ff <= csr_write_data;
      end
   end

   erdm_parser #(
      .MAX_RUNS (MAX_RUNS),
      .CNT_W    (CNT_W)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .clear     (clear),
      .byte_fire (byte_fire),
      .data_byte (req_data_byte),
      .base_vcn  (base_vcn_ff),
      .run_wr    (run_wr),
      .count     (count)
   );

   // Query token entering the chain
   always_comb begin
      tok[0]       = '0;
      tok[0].valid = lookup_fire;
      tok[0].vcn   = req_query_vcn;
      left[0]      = count;
   end

   for (genvar k = 0; k < MAX_RUNS; k++) begin : g_cell
      run_write_type cell_wr;
      always_comb begin
         cell_wr       = run_wr;
         cell_wr.valid = run_wr.valid && (count[IDX_W-1:0] == IDX_W'(k));
      end
      erdm_cell #(
         .CNT_W (CNT_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .run_wr   (cell_wr),
         .tok_in   (tok[k]),
         .left_in  (left[k]),
         .tok_out  (tok[k+1]),
         .left_out (left[k+1])
      );
   end

   assign last_tok = tok[MAX_RUNS];

   // Busy from lookup acceptance until the token leaves the last cell
   always_comb begin
      busy_in = busy_ff;
      if (lookup_fire) begin
         busy_in = 1'b1;
      end else if (last_tok.valid) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   // Response register
   always_comb begin
      strobe_in  = 1'b0;
      kind_in    = RKIND_RUN;
      found_in   = 1'b0;
      start_in   = 32'd0;
      mapped_in  = 32'd0;
      length_in  = 32'd0;
      cleft_in   = 32'd0;
      sparse_in  = 1'b0;
      rcount_sel = count;
      if (last_tok.valid) begin
         strobe_in = 1'b1;
         kind_in   = RKIND_LOOKUP;
         if (last_tok.found) begin
            found_in  = 1'b1;
            start_in  = last_tok.run_start;
            mapped_in = last_tok.sparse ? 32'd0 : (last_tok.lcn + last_tok.offset);
            length_in = last_tok.length;
            cleft_in  = last_tok.length - last_tok.offset;
            sparse_in = last_tok.sparse;
         end
      end else if (run_wr.valid) begin
         strobe_in  = 1'b1;
         start_in   = run_wr.start;
         mapped_in  = run_wr.lcn;
         length_in  = run_wr.length;
         sparse_in  = run_wr.sparse;
         rcount_sel = count + 1'b1;
      end
      rcount_ext = {9'd0, rcount_sel};
      rcount_in  = rcount_ext[8:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
      kind_ff   <= kind_in;
      found_ff  <= found_in;
      start_ff  <= start_in;
      mapped_ff <= mapped_in;
      length_ff <= length_in;
      cleft_ff  <= cleft_in;
      sparse_ff <= sparse_in;
      rcount_ff <= rcount_in;
   end

   assign busy              = busy_ff;
   assign rsp_strobe        = strobe_ff;
   assign rsp_result_kind   = kind_ff;
   assign rsp_found         = found_ff;
   assign rsp_run_start     = start_ff;
   assign rsp_mapped_lcn    = mapped_ff;
   assign rsp_run_length    = length_ff;
   assign rsp_clusters_left = cleft_ff;
   assign rsp_is_sparse     = sparse_ff;
   assign rsp_run_count     = rcount_ff;

   // A lookup answer only follows a walk that held busy
   a_lookup_after_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_result_kind == RKIND_LOOKUP)) |-> $past(busy))
      else $error("lookup answer without a walk in progress");

   // The chain only carries a token while busy
   a_token_while_busy: assert property (@(posedge clock) disable iff (reset)
      last_tok.valid |-> busy_ff)
      else $error("token left the chain while idle");

   // Decoded runs never carry a hit flag
   a_found_only_lookup: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_found) |-> (rsp_result_kind == RKIND_LOOKUP))
      else $error("found set on a run response");

   // Holes always map to cluster zero
   a_sparse_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_is_sparse) |-> (rsp_mapped_lcn == 32'd0))
      else $error("sparse response with nonzero cluster");

   // The table never overfills
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      run_wr.valid |-> ({1'b0, count} < (CNT_W+1)'(MAX_RUNS)))
      else $error("run written into a full table");

endmodule
